// File: hdl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types, widths and helpers for the sorted insert priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sipq_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_W     = 16;
  localparam int PAYLOAD_W = 16;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = KEY_W + PAYLOAD_W;

  localparam int IN_BITS  = KEY_W + PAYLOAD_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = KEY_W + PAYLOAD_W + STATUS_W + CNT_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Bit offsets of the result fields inside m_tdata.
  localparam int OUT_STATUS_LSB = KEY_W + PAYLOAD_W;
  localparam int OUT_OCC_LSB    = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_EMPTY_BIT  = OUT_OCC_LSB + CNT_W;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_W-1:0]     key;
  } entry_t;

  // Physical slot of the entry that sits off places behind the head.
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // True when a new key ranks in front of a stored key; ties go in front.
  function automatic logic goes_before(input logic             lowest_first,
                                       input logic [KEY_W-1:0] new_key,
                                       input logic [KEY_W-1:0] old_key);
    if (lowest_first) begin
      return new_key <= old_key;
    end
    return new_key >= old_key;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sipq_ram.sv
// ----------------------------------------------------------------------------
// sipq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue kept as a sorted list in a ring-addressed RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Operations arrive on the s_ channel: s_tuser is the operation (0 push,
//   1 pop) and s_tdata carries the key and payload of a push. Every
//   operation produces exactly one result transfer on the m_ channel with
//   the popped key and payload (zero for a push), a status code, the
//   occupancy afterwards and an empty flag.
//   cfg_we writes cfg_wdata into the order bit (0 highest key first,
//   1 lowest key first); write it only while the queue is idle.
//   Timing: one operation is worked on at a time. A pop reads the head
//   entry and then registers it as the result; a push walks the list from
//   the head one entry per cycle, and every entry behind the insertion point
//   is moved back one slot through the single RAM read and write port. Pop
//   on empty, push on full and push on empty go straight to the result.
//   The next operation is taken as soon as the result sits in the output
//   register, even if the receiver has not taken it yet; while the
//   receiver stalls a finished result waits and no new operation is taken.
//   Reset empties the queue and selects highest key first; the RAM itself
//   is not cleared since only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_insert_priority_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_wdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // s_tdata: key [15:0], payload [31:16]
  input  wire logic [sipq_pkg::IN_W-1:0] s_tdata,
  // s_tuser: func (0 push, 1 pop)
  input  wire logic                      s_tuser,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // m_tdata: out_key [15:0], out_payload [31:16], status [33:32],
  //          occupancy [38:34], is_empty [39]
  output logic [sipq_pkg::OUT_W-1:0]     m_tdata
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_PUSH_CMP = 5'b00010,
    ST_PUSH_PUT = 5'b00100,
    ST_POP_WAIT = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t state, state_next;

  logic                           order_low;
  logic [sipq_pkg::IDX_W-1:0]     head, head_next;
  logic [sipq_pkg::CNT_W-1:0]     count, count_next;
  logic [sipq_pkg::CNT_W-1:0]     pos, pos_next;
  logic                           found, found_next;
  logic [sipq_pkg::KEY_W-1:0]     new_key, new_key_next;
  logic [sipq_pkg::PAYLOAD_W-1:0] new_payload, new_payload_next;
  logic [sipq_pkg::STATUS_W-1:0]  res_status, res_status_next;
  sipq_pkg::entry_t               res_entry, res_entry_next;

  logic [sipq_pkg::KEY_W-1:0]     out_key;
  logic [sipq_pkg::PAYLOAD_W-1:0] out_payload;
  logic [sipq_pkg::STATUS_W-1:0]  out_status;
  logic [sipq_pkg::CNT_W-1:0]     out_occ;
  logic                           out_empty;
  logic                           out_load;

  logic                       ram_we;
  logic [sipq_pkg::IDX_W-1:0] ram_waddr;
  sipq_pkg::entry_t           ram_wdata;
  logic                       ram_re;
  logic [sipq_pkg::IDX_W-1:0] ram_raddr;
  sipq_pkg::entry_t           ram_rdata;
  sipq_pkg::entry_t           new_entry;

  logic accept;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign new_entry = '{payload: new_payload, key: new_key};

  sipq_ram #(
    .WIDTH (sipq_pkg::ENTRY_W),
    .DEPTH (sipq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next       = state;
    head_next        = head;
    count_next       = count;
    pos_next         = pos;
    found_next       = found;
    new_key_next     = new_key;
    new_payload_next = new_payload;
    res_status_next  = res_status;
    res_entry_next   = res_entry;
    ram_we           = 1'b0;
    ram_waddr        = head;
    ram_wdata        = new_entry;
    ram_re           = 1'b0;
    ram_raddr        = head;
    out_load         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          new_key_next     = s_tdata[sipq_pkg::KEY_W-1:0];
          new_payload_next = s_tdata[sipq_pkg::KEY_W +: sipq_pkg::PAYLOAD_W];
          res_status_next  = sipq_pkg::STATUS_OK;
          res_entry_next   = '0;
          if (s_tuser == sipq_pkg::FUNC_POP) begin
            if (count == '0) begin
              res_status_next = sipq_pkg::STATUS_EMPTY;
              state_next      = ST_DONE;
            end else begin
              ram_re     = 1'b1;
              ram_raddr  = head;
              state_next = ST_POP_WAIT;
            end
          end else begin
            if (count == sipq_pkg::CNT_W'(sipq_pkg::DEPTH)) begin
              res_status_next = sipq_pkg::STATUS_FULL;
              state_next      = ST_DONE;
            end else if (count == '0) begin
              ram_we     = 1'b1;
              ram_waddr  = head;
              ram_wdata  = '{payload: new_payload_next, key: new_key_next};
              count_next = count + 1'b1;
              state_next = ST_DONE;
            end else begin
              // Walk from the head toward the tail, one entry per cycle.
              pos_next   = '0;
              found_next = 1'b0;
              ram_re     = 1'b1;
              ram_raddr  = head;
              state_next = ST_PUSH_CMP;
            end
          end
        end
      end

      ST_PUSH_CMP: begin
        // From the insertion point on, each stored entry is replaced by the
        // carried one and is itself carried one slot further back.
        if (found || sipq_pkg::goes_before(order_low, new_key, ram_rdata.key)) begin
          ram_we           = 1'b1;
          ram_waddr        = sipq_pkg::slot_addr(head, pos);
          ram_wdata        = new_entry;
          new_key_next     = ram_rdata.key;
          new_payload_next = ram_rdata.payload;
          found_next       = 1'b1;
        end
        pos_next = pos + sipq_pkg::CNT_W'(1);
        if (pos == count - sipq_pkg::CNT_W'(1)) begin
          state_next = ST_PUSH_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = sipq_pkg::slot_addr(head, pos + sipq_pkg::CNT_W'(1));
        end
      end

      ST_PUSH_PUT: begin
        ram_we     = 1'b1;
        ram_waddr  = sipq_pkg::slot_addr(head, count);
        ram_wdata  = new_entry;
        count_next = count + 1'b1;
        state_next = ST_DONE;
      end

      ST_POP_WAIT: begin
        res_entry_next = ram_rdata;
        head_next      = sipq_pkg::slot_addr(head, sipq_pkg::CNT_W'(1));
        count_next     = count - 1'b1;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      order_low <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (cfg_we) begin
        order_low <= cfg_wdata;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    found       <= found_next;
    new_key     <= new_key_next;
    new_payload <= new_payload_next;
    res_status  <= res_status_next;
    res_entry   <= res_entry_next;
    if (out_load) begin
      out_key     <= res_entry.key;
      out_payload <= res_entry.payload;
      out_status  <= res_status;
      out_occ     <= count;
      out_empty   <= (count == '0);
    end
  end

  assign m_tdata = sipq_pkg::OUT_W'({out_empty, out_occ, out_status, out_payload, out_key});

endmodule

`default_nettype wire

// File: hdl/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker
// Port-level checks on the result channel of the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sipq_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [sipq_pkg::OUT_W-1:0] m_tdata
);

  logic [sipq_pkg::KEY_W-1:0]     chk_key;
  logic [sipq_pkg::PAYLOAD_W-1:0] chk_payload;
  logic [sipq_pkg::STATUS_W-1:0]  chk_status;
  logic [sipq_pkg::CNT_W-1:0]     chk_occ;
  logic                           chk_empty;

  assign chk_key     = m_tdata[sipq_pkg::KEY_W-1:0];
  assign chk_payload = m_tdata[sipq_pkg::KEY_W +: sipq_pkg::PAYLOAD_W];
  assign chk_status  = m_tdata[sipq_pkg::OUT_STATUS_LSB +: sipq_pkg::STATUS_W];
  assign chk_occ     = m_tdata[sipq_pkg::OUT_OCC_LSB +: sipq_pkg::CNT_W];
  assign chk_empty   = m_tdata[sipq_pkg::OUT_EMPTY_BIT];

  // A stalled result must hold its value until the transfer.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_occ <= sipq_pkg::CNT_W'(sipq_pkg::DEPTH))
    else $error("occupancy above depth");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> chk_empty == (chk_occ == '0))
    else $error("empty flag disagrees with occupancy");

  // A pop on an empty queue leaves it empty and returns no data.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_status == sipq_pkg::STATUS_EMPTY |->
      chk_occ == '0 && chk_key == '0 && chk_payload == '0)
    else $error("bad pop on empty result");

  a_push_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && chk_status == sipq_pkg::STATUS_FULL |->
      chk_occ == sipq_pkg::CNT_W'(sipq_pkg::DEPTH))
    else $error("full push reported below depth");

endmodule

bind sorted_insert_priority_queue sipq_checker u_sipq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/sorted_insert_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_tb
// Self-checking bench for the sorted insert priority queue. A driver feeds
// push and pop operations from a queue of pending items, and a monitor runs
// each accepted operation through a behavioral sorted list. It then compares
// every result transfer field by field. Both channel sides idle at random,
// and the order register is switched between phases while the queue is idle.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_tb;
  import sipq_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_WAIT    = 17;
  localparam int PHASES      = 8;
  localparam int PHASE_OPS   = 172;

  typedef struct packed {
    logic                 func;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } queue_op_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [STATUS_W-1:0]  status;
    logic [CNT_W-1:0]     occupancy;
    logic                 is_empty;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tuser = 1'b0;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tready = 1'b0;
  wire s_tready;
  wire m_tvalid;
  wire [OUT_W-1:0] m_tdata;

  // Behavioral copy of the sorted list, head at index 0.
  logic [KEY_W-1:0]     list_keys     [DEPTH];
  logic [PAYLOAD_W-1:0] list_payloads [DEPTH];
  int                   list_count = 0;
  logic                 lowest_first = 1'b0;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];

  int   errors = 0;
  int   cycles = 0;
  bit   op_taken = 1'b0;
  bit   result_taken = 1'b0;
  int   send_gap = 0;
  int   recv_stall = 0;
  int   calm_left = 0;
  int   planned_count = 0;
  int   ops_added = 0;

  sorted_insert_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic queue_result_t list_apply(queue_op_t op);
    queue_result_t r;
    int            pos;
    r = '0;
    if (op.func == FUNC_PUSH) begin
      if (list_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        // Skip the entries that keep their place in front of the new key.
        while (pos < list_count &&
               !(lowest_first ? (op.key <= list_keys[pos]) : (op.key >= list_keys[pos]))) begin
          pos++;
        end
        for (int j = list_count; j > pos; j--) begin
          list_keys[j]     = list_keys[j-1];
          list_payloads[j] = list_payloads[j-1];
        end
        list_keys[pos]     = op.key;
        list_payloads[pos] = op.payload;
        list_count++;
        r.status = STATUS_OK;
      end
    end else begin
      if (list_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.key     = list_keys[0];
        r.payload = list_payloads[0];
        for (int j = 1; j < list_count; j++) begin
          list_keys[j-1]     = list_keys[j];
          list_payloads[j-1] = list_payloads[j];
        end
        list_count--;
        r.status = STATUS_OK;
      end
    end
    r.occupancy = CNT_W'(list_count);
    r.is_empty  = (list_count == 0);
    return r;
  endfunction

  // Mostly random waits, with the occasional run of back-to-back transfers.
  function automatic int pick_wait();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 30) == 0) begin
      calm_left = $urandom_range(8, 40);
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Sender side: present one operation at a time, with a random gap after each; also stall m_tready at random.
  always @(negedge clk) begin : sender
    queue_op_t op;
    if (!rst) begin
      if (!s_tvalid || op_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op = pending_ops.pop_front();
          s_tuser  <= op.func;
          s_tdata  <= IN_W'({op.payload, op.key});
          s_tvalid <= 1'b1;
          send_gap = pick_wait();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (result_taken) begin
        recv_stall = pick_wait();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    queue_op_t     op;
    queue_result_t got;
    queue_result_t want;
    op_taken     = !rst && s_tvalid && s_tready;
    result_taken = !rst && m_tvalid && m_tready;
    if (op_taken) begin
      op.func    = s_tuser;
      op.key     = s_tdata[KEY_W-1:0];
      op.payload = s_tdata[KEY_W +: PAYLOAD_W];
      expected_results.push_back(list_apply(op));
    end
    if (result_taken) begin
      got.key       = m_tdata[KEY_W-1:0];
      got.payload   = m_tdata[KEY_W +: PAYLOAD_W];
      got.status    = m_tdata[OUT_STATUS_LSB +: STATUS_W];
      got.occupancy = m_tdata[OUT_OCC_LSB +: CNT_W];
      got.is_empty  = m_tdata[OUT_EMPTY_BIT];
      if (expected_results.size() == 0) begin
        $error("result transfer with no operation outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.key !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, got.key);
          errors++;
        end
        if (got.payload !== want.payload) begin
          $error("out_payload: expected %h, got %h", want.payload, got.payload);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
          errors++;
        end
        if (got.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_op(logic func, logic [KEY_W-1:0] key, logic [PAYLOAD_W-1:0] payload);
    queue_op_t op;
    op.func    = func;
    op.key     = key;
    op.payload = payload;
    pending_ops.push_back(op);
    ops_added++;
    if (func == FUNC_PUSH && planned_count < DEPTH) begin
      planned_count++;
    end else if (func == FUNC_POP && planned_count > 0) begin
      planned_count--;
    end
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom_range(0, 3));  // crowds of equal keys
      1: return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
      default: return KEY_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? {PAYLOAD_W{1'b1}} : {PAYLOAD_W{1'b0}};
    end
    return PAYLOAD_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_order(logic value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    lowest_first = value;
    #1;
  endtask

  // Empty pop, key and payload extremes, ties in the middle and ties at
  // either end of the list, then a full drain and one more empty pop.
  task automatic directed_ops();
    add_op(FUNC_POP,  16'h0000, 16'hFFFF);
    add_op(FUNC_PUSH, 16'h0000, 16'h0000);
    add_op(FUNC_PUSH, 16'hFFFF, 16'hFFFF);
    add_op(FUNC_PUSH, 16'h8000, 16'hAAAA);
    add_op(FUNC_PUSH, 16'h8000, 16'h5555);
    add_op(FUNC_PUSH, 16'hFFFF, 16'h1234);
    add_op(FUNC_PUSH, 16'h0000, 16'h4321);
    repeat (6) add_op(FUNC_POP, 16'hFFFF, 16'h0000);
    add_op(FUNC_POP, 16'h0000, 16'h0000);
  endtask

  initial begin : stimulus
    int phase_end;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    #1;

    directed_ops();
    wait_idle();
    write_order(1'b1);
    directed_ops();
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_order(ph[0]);
      phase_end = ops_added + PHASE_OPS;
      while (ops_added < phase_end) begin
        case ($urandom_range(0, 5))
          0, 1: begin
            // Fill up, then push a few more into the full queue.
            while (planned_count < DEPTH) add_op(FUNC_PUSH, rand_key(), rand_payload());
            repeat ($urandom_range(0, 3)) add_op(FUNC_PUSH, rand_key(), rand_payload());
          end
          2: begin
            while (planned_count > 0) add_op(FUNC_POP, rand_key(), rand_payload());
            repeat ($urandom_range(0, 2)) add_op(FUNC_POP, rand_key(), rand_payload());
          end
          default: begin
            repeat (16) begin
              add_op(($urandom_range(0, 9) < 6) ? FUNC_PUSH : FUNC_POP,
                     rand_key(), rand_payload());
            end
          end
        endcase
      end
      wait_idle();
    end

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sorted_insert_priority_queue.f
hdl/sipq_pkg.sv
hdl/sipq_ram.sv
hdl/sorted_insert_priority_queue.sv
hdl/sipq_checker.sv
verif/sorted_insert_priority_queue_tb.sv
